### hw/rtl/b64d_pkg.sv
// Shared types and constants of the base64 stream decoder.
package b64d_pkg;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ALPHABET_SELECT = 3'd0;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_VALID = 2'd1,
    STATUS_BAD_PAD  = 2'd2
  } status_t;

  // One decoded group handed from the front end to the output sequencer.
  typedef struct packed {
    logic [23:0] word;      // three bytes, first byte in the top bits
    logic [1:0]  nbytes;    // bytes kept from word, 0..3
    logic        msg_end;   // this entry closes the message
    status_t     status;    // message status, meaningful with msg_end
  } job_t;

endpackage

### hw/rtl/b64d_if.sv
// Stream channel interfaces: encoded characters in, decoded bytes out.
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       end_of_input;

  modport source (output valid, output in_char, output end_of_input, input ready);
  modport sink   (input valid, input in_char, input end_of_input, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       run_last;
  logic       message_end;
  logic [1:0] status;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output message_end, output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input message_end, input status, output ready);
endinterface

### hw/rtl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: channels, register port and sub-blocks.
//
//   channel   dir  kind          payload
//   in_chan   in   valid/ready   in_char[7:0], end_of_input
//   out_chan  out  valid/ready   out_byte[7:0], byte_valid, run_last, message_end, status[1:0]
//   APB       in   psel/penable  alphabet_select at byte address 0 (bit 0)
//
// One character per cycle is accepted while the queue has room; the front end decodes it
// in the same cycle and queues a job of zero to three bytes. The output sequencer sends one
// result per cycle if out_chan is ready; a four-character group yields at most three results.
// The two-entry job queue sets the slack: input stalls only while the queue is full.
// Reset (rst, synchronous) clears the group state, the queue and alphabet_select.
// The output side may stall at will; results hold until transferred.
module base64_stream_decoder
  import b64d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  b64d_in_if.sink            in_chan,
  b64d_out_if.source         out_chan,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic alphabet_select;
  logic cfg_write;

  logic job_push;
  logic job_can_push;
  logic job_pop;
  logic job_avail;
  job_t front_job;
  job_t head_job;

  // Register port: zero-wait writes, decode on the word address only.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      alphabet_select <= 1'b0;
    end else if (cfg_write && paddr[PADDR_W-1:2] == REG_ALPHABET_SELECT[PADDR_W-1:2]) begin
      alphabet_select <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_ALPHABET_SELECT[PADDR_W-1:2]) begin
      prdata[0] = alphabet_select;
    end
  end

  // Front end: classify the character and advance the group state on each transfer.
  b64d_front u_front (
    .clk             (clk),
    .rst             (rst),
    .alphabet_select (alphabet_select),
    .in_valid        (in_chan.valid),
    .in_char         (in_chan.in_char),
    .end_of_input    (in_chan.end_of_input),
    .in_ready        (in_chan.ready),
    .job_ready       (job_can_push),
    .job_push        (job_push),
    .job             (front_job)
  );

  // Queue: decouple character intake from byte output.
  b64d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_job  (front_job),
    .can_push  (job_can_push),
    .pop       (job_pop),
    .not_empty (job_avail),
    .head      (head_job)
  );

  // Back end: drop the head job once its last result is transferred.
  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_avail),
    .job         (head_job),
    .job_pop     (job_pop),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_byte    (out_chan.out_byte),
    .byte_valid  (out_chan.byte_valid),
    .run_last    (out_chan.run_last),
    .message_end (out_chan.message_end),
    .status      (out_chan.status)
  );

endmodule

### hw/rtl/b64d_front.sv
// Front end: character classification, group assembly and padding rules.
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       alphabet_select,
  input  logic       in_valid,
  input  logic [7:0] in_char,
  input  logic       end_of_input,
  output logic       in_ready,
  input  logic       job_ready,
  output logic       job_push,
  output job_t       job
);

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  logic [17:0] sextet_store, sextet_store_next;
  logic [1:0]  group_fill, group_fill_next;
  logic [2:0]  pad_count, pad_count_next;
  logic        stopped, stopped_next;
  logic        seen_valid, seen_valid_next;
  logic        bad_pad, bad_pad_next;

  logic        is_sym;
  logic [5:0]  sym;
  logic        take;
  logic        is_pad;
  logic [2:0]  pad_inc;
  logic [2:0]  pad_total;
  logic [23:0] word;
  logic [1:0]  nbytes;

  // Map a character to its sextet; pad decodes as zero.
  function automatic logic [6:0] decode_char(input logic [7:0] c, input logic url);
    logic [6:0] r;
    r = 7'd0;
    if (c >= 8'h41 && c <= 8'h5A)      r = {1'b1, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b1, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 6'(c - 8'h30 + 8'd52)};
    else if (c == CHAR_PAD)            r = {1'b1, 6'd0};
    else if (!url && c == 8'h2B)       r = {1'b1, 6'd62};
    else if (!url && c == 8'h2F)       r = {1'b1, 6'd63};
    else if (url && c == 8'h2D)        r = {1'b1, 6'd62};
    else if (url && c == 8'h5F)        r = {1'b1, 6'd63};
    return r;
  endfunction

  // Bytes kept by a completed group, from its pad count.
  function automatic logic [1:0] keep_of(input logic [2:0] pads);
    logic [1:0] k;
    unique case (pads)
      3'd0:    k = 2'd3;
      3'd1:    k = 2'd2;
      3'd2:    k = 2'd1;
      default: k = 2'd0;
    endcase
    return k;
  endfunction

  assign {is_sym, sym} = decode_char(in_char, alphabet_select);
  assign is_pad   = (in_char == CHAR_PAD);
  assign take     = !stopped && is_sym;
  assign in_ready = job_ready;

  always_comb begin
    sextet_store_next = sextet_store;
    group_fill_next   = group_fill;
    pad_count_next    = pad_count;
    stopped_next      = stopped;
    seen_valid_next   = seen_valid | take;
    bad_pad_next      = bad_pad;
    word              = 24'd0;
    nbytes            = 2'd0;
    pad_inc           = 3'd0;
    pad_total         = 3'd0;

    if (take) begin
      pad_total = pad_count + {2'b00, is_pad};
      if (group_fill != 2'd3) begin
        sextet_store_next = {sextet_store[11:0], sym};
        group_fill_next   = group_fill + 2'd1;
        pad_count_next    = pad_total;
      end else begin
        word              = {sextet_store, sym};
        nbytes            = keep_of(pad_total);
        bad_pad_next      = bad_pad | (pad_total >= 3'd3);
        stopped_next      = (pad_total != 3'd0);
        sextet_store_next = 18'd0;
        group_fill_next   = 2'd0;
        pad_count_next    = 3'd0;
      end
    end

    // Close a partial group with implied pads at end of message.
    if (end_of_input && !stopped_next && group_fill_next != 2'd0) begin
      unique case (group_fill_next)
        2'd1:    word = {sextet_store_next[5:0], 18'd0};
        2'd2:    word = {sextet_store_next[11:0], 12'd0};
        default: word = {sextet_store_next, 6'd0};
      endcase
      pad_inc      = 3'd4 - {1'b0, group_fill_next};
      pad_total    = pad_count_next + pad_inc;
      nbytes       = keep_of(pad_total);
      bad_pad_next = bad_pad_next | (pad_total >= 3'd3);
    end
  end

  always_comb begin
    job.word    = word;
    job.nbytes  = nbytes;
    job.msg_end = end_of_input;
    if (!seen_valid_next)  job.status = STATUS_NO_VALID;
    else if (bad_pad_next) job.status = STATUS_BAD_PAD;
    else                   job.status = STATUS_OK;
  end

  assign job_push = in_valid && in_ready && (nbytes != 2'd0 || end_of_input);

  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_store <= '0;
      group_fill   <= '0;
      pad_count    <= '0;
      stopped      <= 1'b0;
      seen_valid   <= 1'b0;
      bad_pad      <= 1'b0;
    end else if (in_valid && in_ready) begin
      if (end_of_input) begin
        sextet_store <= '0;
        group_fill   <= '0;
        pad_count    <= '0;
        stopped      <= 1'b0;
        seen_valid   <= 1'b0;
        bad_pad      <= 1'b0;
      end else begin
        sextet_store <= sextet_store_next;
        group_fill   <= group_fill_next;
        pad_count    <= pad_count_next;
        stopped      <= stopped_next;
        seen_valid   <= seen_valid_next;
        bad_pad      <= bad_pad_next;
      end
    end
  end

endmodule

### hw/rtl/b64d_queue.sv
// Short job queue between the front end and the output sequencer.
module b64d_queue
  import b64d_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic can_push,
  input  logic pop,
  output logic not_empty,
  output job_t head
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign can_push  = (count != QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hw/rtl/b64d_back.sv
// Output sequencer: splits each queued job into byte results.
module b64d_back
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  job_t       job,
  output logic       job_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       run_last,
  output logic       message_end,
  output logic [1:0] status
);

  logic [1:0] idx;
  logic [1:0] last_idx;
  logic       xfer;

  assign last_idx    = (job.nbytes == 2'd0) ? 2'd0 : job.nbytes - 2'd1;
  assign out_valid   = job_valid;
  assign byte_valid  = (job.nbytes != 2'd0);
  assign run_last    = (idx == last_idx);
  assign message_end = run_last && job.msg_end;
  assign status      = message_end ? job.status : STATUS_OK;
  assign xfer        = out_valid && out_ready;
  assign job_pop     = xfer && run_last;

  always_comb begin
    out_byte = 8'd0;
    if (byte_valid) begin
      unique case (idx)
        2'd0:    out_byte = job.word[23:16];
        2'd1:    out_byte = job.word[15:8];
        default: out_byte = job.word[7:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (xfer) begin
      idx <= run_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
